### rtl/rbs_pkg.sv
`timescale 1ns / 1ps
// Shared types, formats and constants for the ray/box slab test.
// Used by rbs_div, rbs_point and ray_box_slab_intersect; no dependencies.
package rbs_pkg;

	localparam int COORD_WIDTH = 32;
	localparam int FRAC_BITS   = 16;

	// ray parameter format: signed, FRAC_BITS fraction bits
	localparam int TW = 64;

	// slab numerator |plane - start| and divisor |dir|
	localparam int NW = COORD_WIDTH + 1;
	localparam int DW = COORD_WIDTH;
	localparam int QW = NW + FRAC_BITS;
	localparam int QXW = (QW > TW) ? QW : TW;

	// quotient bits retired per divider stage
	localparam int DIV_K   = 2;
	localparam int DIV_STG = (QW + DIV_K - 1) / DIV_K;
	localparam int DIV_LAT = DIV_STG + 1;

	localparam int PNT_LAT = 3;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic signed [TW-1:0] tparam_t;

	localparam coord_t C_MAX = coord_t'({1'b0, {(COORD_WIDTH-1){1'b1}}});
	localparam coord_t C_MIN = coord_t'({1'b1, {(COORD_WIDTH-1){1'b0}}});
	localparam logic [TW-1:0] T_LIM = (64'd1 << 62) - 64'd1;
	localparam tparam_t T_BOUND = tparam_t'(64'sd100000 <<< FRAC_BITS);

	typedef enum logic [1:0] {
		KIND_MISS   = 2'd0,
		KIND_HIT    = 2'd1,
		KIND_INSIDE = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		FACE_NONE = 3'd0,
		FACE_NX   = 3'd1,
		FACE_PX   = 3'd2,
		FACE_NY   = 3'd3,
		FACE_PY   = 3'd4,
		FACE_NZ   = 3'd5,
		FACE_PZ   = 3'd6
	} face_t;

	function automatic logic [COORD_WIDTH-1:0] coord_mag(input coord_t v);
		coord_mag = v[COORD_WIDTH-1] ? (~v + 1'b1) : v;
	endfunction

endpackage

### rtl/ray_box_slab_intersect.sv
`timescale 1ns / 1ps
// Ray against axis-aligned box slab test, fully pipelined.
// Depends on rbs_pkg, rbs_div, rbs_point.
//
// One test is accepted every cycle (busy is held low) and its result is
// strobed on result_valid once it has passed the stage-1 registers, the
// six radix-2 slab dividers (two quotient bits per stage, Q16.16 inputs),
// four compare stages and the three-stage point multiplier.
// The receiver cannot stall; results must be captured in their strobe cycle.
module ray_box_slab_intersect import rbs_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	output logic   busy,
	input  coord_t start_x,
	input  coord_t start_y,
	input  coord_t start_z,
	input  coord_t dir_x,
	input  coord_t dir_y,
	input  coord_t dir_z,
	input  coord_t box_min_x,
	input  coord_t box_min_y,
	input  coord_t box_min_z,
	input  coord_t box_max_x,
	input  coord_t box_max_y,
	input  coord_t box_max_z,
	output logic   result_valid,
	output logic [1:0] result_kind,
	output coord_t entry_x,
	output coord_t entry_y,
	output coord_t entry_z,
	output coord_t exit_x,
	output coord_t exit_y,
	output coord_t exit_z,
	output logic [2:0] entry_face,
	output logic [2:0] exit_face
);

	coord_t st [3];
	coord_t dr [3];
	coord_t bl [3];
	coord_t bh [3];

	assign st = '{start_x, start_y, start_z};
	assign dr = '{dir_x, dir_y, dir_z};
	assign bl = '{box_min_x, box_min_y, box_min_z};
	assign bh = '{box_max_x, box_max_y, box_max_z};
	assign busy = 1'b0;

	localparam face_t FNEG [3] = '{FACE_NX, FACE_NY, FACE_NZ};
	localparam face_t FPOS [3] = '{FACE_PX, FACE_PY, FACE_PZ};

	// stage 1: slab numerators, divisors and signs
	logic [NW-1:0] numl_s1 [3];
	logic [NW-1:0] numh_s1 [3];
	logic [DW-1:0] den_s1  [3];
	logic          negl_s1 [3];
	logic          negh_s1 [3];
	coord_t        s_s1    [3];
	coord_t        d_s1    [3];
	logic          perp_s1 [3];
	logic          out_s1;
	logic          v_s1;

	function automatic logic [NW-1:0] abs_diff(input coord_t b, input coord_t s);
		logic signed [NW-1:0] df;
		df = {b[COORD_WIDTH-1], b} - {s[COORD_WIDTH-1], s};
		abs_diff = df[NW-1] ? (~df + 1'b1) : df;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		for (int a = 0; a < 3; a++) begin
			numl_s1[a] <= abs_diff(bl[a], st[a]);
			numh_s1[a] <= abs_diff(bh[a], st[a]);
			den_s1[a]  <= coord_mag(dr[a]);
			negl_s1[a] <= (bl[a] < st[a]) != dr[a][COORD_WIDTH-1];
			negh_s1[a] <= (bh[a] < st[a]) != dr[a][COORD_WIDTH-1];
			s_s1[a]    <= st[a];
			d_s1[a]    <= dr[a];
			perp_s1[a] <= (dr[a] == '0);
		end
		out_s1 <= ((dr[0] == '0) && (st[0] < bl[0] || st[0] > bh[0])) ||
		          ((dr[1] == '0) && (st[1] < bl[1] || st[1] > bh[1])) ||
		          ((dr[2] == '0) && (st[2] < bl[2] || st[2] > bh[2]));
	end

	// slab parameters
	tparam_t tl [3];
	tparam_t th [3];
	logic    tv [3][2];

	for (genvar a = 0; a < 3; a++) begin : g_axis
		rbs_div u_div_lo (
			.clk    (clk),
			.arst_n (arst_n),
			.vld    (v_s1),
			.num    (numl_s1[a]),
			.den    (den_s1[a]),
			.neg    (negl_s1[a]),
			.t_vld  (tv[a][0]),
			.t      (tl[a])
		);
		rbs_div u_div_hi (
			.clk    (clk),
			.arst_n (arst_n),
			.vld    (v_s1),
			.num    (numh_s1[a]),
			.den    (den_s1[a]),
			.neg    (negh_s1[a]),
			.t_vld  (tv[a][1]),
			.t      (th[a])
		);
	end

	coord_t s_dly_s    [DIV_LAT][3];
	coord_t d_dly_s    [DIV_LAT][3];
	logic   perp_dly_s [DIV_LAT][3];
	logic   out_dly_s  [DIV_LAT];

	always_ff @(posedge clk) begin
		s_dly_s[0]    <= s_s1;
		d_dly_s[0]    <= d_s1;
		perp_dly_s[0] <= perp_s1;
		out_dly_s[0]  <= out_s1;
		for (int i = 1; i < DIV_LAT; i++) begin
			s_dly_s[i]    <= s_dly_s[i-1];
			d_dly_s[i]    <= d_dly_s[i-1];
			perp_dly_s[i] <= perp_dly_s[i-1];
			out_dly_s[i]  <= out_dly_s[i-1];
		end
	end

	// stage 2: near/far per axis
	tparam_t tn_s2 [3];
	tparam_t tf_s2 [3];
	face_t   fn_s2 [3];
	face_t   ff_s2 [3];
	coord_t  s_s2  [3];
	coord_t  d_s2  [3];
	logic    perp_s2 [3];
	logic    out_s2;
	logic    v_s2;

	always_ff @(posedge clk) begin
		for (int a = 0; a < 3; a++) begin
			if (th[a] > tl[a]) begin
				tn_s2[a] <= tl[a];
				fn_s2[a] <= FNEG[a];
				tf_s2[a] <= th[a];
				ff_s2[a] <= FPOS[a];
			end else begin
				tn_s2[a] <= th[a];
				fn_s2[a] <= FPOS[a];
				tf_s2[a] <= tl[a];
				ff_s2[a] <= FNEG[a];
			end
		end
		s_s2    <= s_dly_s[DIV_LAT-1];
		d_s2    <= d_dly_s[DIV_LAT-1];
		perp_s2 <= perp_dly_s[DIV_LAT-1];
		out_s2  <= out_dly_s[DIV_LAT-1];
	end

	// stage 3: x then y
	tparam_t t0_s3;
	tparam_t t1_s3;
	face_t   f0_s3;
	face_t   f1_s3;
	tparam_t tnz_s3;
	tparam_t tfz_s3;
	face_t   fnz_s3;
	face_t   ffz_s3;
	logic    perpz_s3;
	coord_t  s_s3 [3];
	coord_t  d_s3 [3];
	logic    out_s3;
	logic    v_s3;

	tparam_t t0x;
	tparam_t t1x;
	face_t   f0x;
	face_t   f1x;
	tparam_t t0y;
	tparam_t t1y;
	face_t   f0y;
	face_t   f1y;

	always_comb begin
		if (perp_s2[0]) begin
			t0x = -T_BOUND;
			t1x = T_BOUND;
			f0x = FACE_NONE;
			f1x = FACE_NONE;
		end else begin
			t0x = tn_s2[0];
			t1x = tf_s2[0];
			f0x = fn_s2[0];
			f1x = ff_s2[0];
		end
		t0y = t0x;
		f0y = f0x;
		t1y = t1x;
		f1y = f1x;
		if (!perp_s2[1]) begin
			if (tn_s2[1] > t0x) begin
				t0y = tn_s2[1];
				f0y = fn_s2[1];
			end
			if (tf_s2[1] < t1x) begin
				t1y = tf_s2[1];
				f1y = ff_s2[1];
			end
		end
	end

	always_ff @(posedge clk) begin
		t0_s3    <= t0y;
		f0_s3    <= f0y;
		t1_s3    <= t1y;
		f1_s3    <= f1y;
		tnz_s3   <= tn_s2[2];
		tfz_s3   <= tf_s2[2];
		fnz_s3   <= fn_s2[2];
		ffz_s3   <= ff_s2[2];
		perpz_s3 <= perp_s2[2];
		s_s3     <= s_s2;
		d_s3     <= d_s2;
		out_s3   <= out_s2;
	end

	// stage 4: z
	tparam_t t0_s4;
	tparam_t t1_s4;
	face_t   f0_s4;
	face_t   f1_s4;
	coord_t  s_s4 [3];
	coord_t  d_s4 [3];
	logic    out_s4;
	logic    v_s4;

	tparam_t t0z;
	tparam_t t1z;
	face_t   f0z;
	face_t   f1z;

	always_comb begin
		t0z = t0_s3;
		f0z = f0_s3;
		t1z = t1_s3;
		f1z = f1_s3;
		if (!perpz_s3) begin
			if (tnz_s3 > t0_s3) begin
				t0z = tnz_s3;
				f0z = fnz_s3;
			end
			if (tfz_s3 < t1_s3) begin
				t1z = tfz_s3;
				f1z = ffz_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		t0_s4  <= t0z;
		f0_s4  <= f0z;
		t1_s4  <= t1z;
		f1_s4  <= f1z;
		s_s4   <= s_s3;
		d_s4   <= d_s3;
		out_s4 <= out_s3;
	end

	// stage 5: classify
	kind_t         kind_s5;
	face_t         f0_s5;
	face_t         f1_s5;
	logic [TW-2:0] t0_s5;
	logic [TW-2:0] t1_s5;
	coord_t        s_s5 [3];
	coord_t        d_s5 [3];
	logic          v_s5;

	logic          miss;
	kind_t         kind_n;
	face_t         f0_n;
	face_t         f1_n;
	logic [TW-2:0] t0_n;

	assign miss = out_s4 || (t0_s4 > t1_s4) ||
	              (t0_s4[TW-1] && t1_s4[TW-1]);

	always_comb begin
		t0_n = t0_s4[TW-2:0];
		f0_n = FACE_NONE;
		f1_n = FACE_NONE;
		if (miss) begin
			kind_n = KIND_MISS;
		end else if (t0_s4[TW-1]) begin
			kind_n = KIND_INSIDE;
			f1_n   = f1_s4;
			t0_n   = '0;
		end else begin
			kind_n = KIND_HIT;
			f0_n   = f0_s4;
			f1_n   = f1_s4;
		end
	end

	always_ff @(posedge clk) begin
		t1_s5   <= t1_s4[TW-2:0];
		t0_s5   <= t0_n;
		f0_s5   <= f0_n;
		f1_s5   <= f1_n;
		kind_s5 <= kind_n;
		s_s5    <= s_s4;
		d_s5    <= d_s4;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s2 <= tv[0][0];
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// points
	coord_t p_ent [3];
	coord_t p_ext [3];

	for (genvar a = 0; a < 3; a++) begin : g_pnt
		rbs_point u_ent (
			.clk (clk),
			.s   (s_s5[a]),
			.d   (d_s5[a]),
			.t   (t0_s5),
			.p   (p_ent[a])
		);
		rbs_point u_ext (
			.clk (clk),
			.s   (s_s5[a]),
			.d   (d_s5[a]),
			.t   (t1_s5),
			.p   (p_ext[a])
		);
	end

	kind_t kind_dly_s [PNT_LAT];
	face_t f0_dly_s   [PNT_LAT];
	face_t f1_dly_s   [PNT_LAT];
	logic  v_dly_s    [PNT_LAT];

	always_ff @(posedge clk) begin
		kind_dly_s[0] <= kind_s5;
		f0_dly_s[0]   <= f0_s5;
		f1_dly_s[0]   <= f1_s5;
		for (int i = 1; i < PNT_LAT; i++) begin
			kind_dly_s[i] <= kind_dly_s[i-1];
			f0_dly_s[i]   <= f0_dly_s[i-1];
			f1_dly_s[i]   <= f1_dly_s[i-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PNT_LAT; i++) begin
				v_dly_s[i] <= 1'b0;
			end
		end else begin
			v_dly_s[0] <= v_s5;
			for (int i = 1; i < PNT_LAT; i++) begin
				v_dly_s[i] <= v_dly_s[i-1];
			end
		end
	end

	kind_t k_o;
	logic  has_ent;
	logic  has_ext;

	assign k_o     = kind_dly_s[PNT_LAT-1];
	assign has_ent = (k_o == KIND_HIT);
	assign has_ext = (k_o != KIND_MISS);

	assign result_valid = v_dly_s[PNT_LAT-1];
	assign result_kind  = k_o;
	assign entry_x      = has_ent ? p_ent[0] : '0;
	assign entry_y      = has_ent ? p_ent[1] : '0;
	assign entry_z      = has_ent ? p_ent[2] : '0;
	assign exit_x       = has_ext ? p_ext[0] : '0;
	assign exit_y       = has_ext ? p_ext[1] : '0;
	assign exit_z       = has_ext ? p_ext[2] : '0;
	assign entry_face   = f0_dly_s[PNT_LAT-1];
	assign exit_face    = f1_dly_s[PNT_LAT-1];

endmodule

### rtl/rbs_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider: ((num << FRAC_BITS) / den), signed and saturated.
// Depends on rbs_pkg.
module rbs_div import rbs_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            vld,
	input  logic [NW-1:0]   num,
	input  logic [DW-1:0]   den,
	input  logic            neg,
	output logic            t_vld,
	output tparam_t         t
);

	logic [QW-1:0] x_s [DIV_STG+1];
	logic [QW-1:0] q_s [DIV_STG+1];
	logic [DW:0]   r_s [DIV_STG+1];
	logic [DW-1:0] d_s [DIV_STG+1];
	logic          n_s [DIV_STG+1];
	logic          v_s [DIV_STG+1];

	assign x_s[0] = {num, {FRAC_BITS{1'b0}}};
	assign q_s[0] = '0;
	assign r_s[0] = '0;
	assign d_s[0] = den;
	assign n_s[0] = neg;
	assign v_s[0] = vld;

	for (genvar j = 0; j < DIV_STG; j++) begin : g_stg
		logic [QW-1:0] x_n;
		logic [QW-1:0] q_n;
		logic [DW:0]   r_n;

		always_comb begin
			x_n = x_s[j];
			q_n = q_s[j];
			r_n = r_s[j];
			for (int k = 0; k < DIV_K; k++) begin
				if (j * DIV_K + k < QW) begin
					r_n = {r_n[DW-1:0], x_n[QW-1]};
					x_n = {x_n[QW-2:0], 1'b0};
					if (r_n >= {1'b0, d_s[j]}) begin
						r_n = r_n - {1'b0, d_s[j]};
						q_n = {q_n[QW-2:0], 1'b1};
					end else begin
						q_n = {q_n[QW-2:0], 1'b0};
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j+1] <= 1'b0;
			end else begin
				v_s[j+1] <= v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			x_s[j+1] <= x_n;
			q_s[j+1] <= q_n;
			r_s[j+1] <= r_n;
			d_s[j+1] <= d_s[j];
			n_s[j+1] <= n_s[j];
		end
	end

	logic [QXW-1:0] q_x;
	logic [TW-2:0]  q_m;

	always_comb begin
		q_x = QXW'(q_s[DIV_STG]);
		if (q_x > QXW'(T_LIM)) begin
			q_m = (TW-1)'(T_LIM);
		end else begin
			q_m = (TW-1)'(q_x);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t_vld <= 1'b0;
		end else begin
			t_vld <= v_s[DIV_STG];
		end
	end

	always_ff @(posedge clk) begin
		t <= n_s[DIV_STG] ? -tparam_t'({1'b0, q_m}) : tparam_t'({1'b0, q_m});
	end

endmodule

### rtl/rbs_point.sv
`timescale 1ns / 1ps
// Point along the ray: start + dir * t, saturated to the coordinate range.
// Three register stages; depends on rbs_pkg.
module rbs_point import rbs_pkg::*; (
	input  logic          clk,
	input  coord_t        s,
	input  coord_t        d,
	input  logic [TW-2:0] t,
	output coord_t        p
);

	localparam int PW = COORD_WIDTH + TW - 1;
	localparam int SW = PW - FRAC_BITS;

	logic [COORD_WIDTH+31:0]     plo_s1;
	logic [COORD_WIDTH+TW-34:0]  phi_s1;
	logic                        neg_s1;
	coord_t                      s_s1;
	logic [COORD_WIDTH-1:0]      dm;

	logic [PW-1:0]               prod_s2;
	logic [COORD_WIDTH:0]        room_s2;
	logic                        neg_s2;
	coord_t                      s_s2;

	logic [SW-1:0]               sh;

	assign dm = coord_mag(d);
	assign sh = SW'(prod_s2 >> FRAC_BITS);

	always_ff @(posedge clk) begin
		plo_s1  <= {32'b0, dm} * {{COORD_WIDTH{1'b0}}, t[31:0]};
		phi_s1  <= (COORD_WIDTH+TW-33)'(dm) * (COORD_WIDTH+TW-33)'(t[TW-2:32]);
		neg_s1  <= d[COORD_WIDTH-1];
		s_s1    <= s;

		prod_s2 <= {phi_s1, 32'b0} + PW'(plo_s1);
		room_s2 <= neg_s1 ? ({s_s1[COORD_WIDTH-1], s_s1} - {C_MIN[COORD_WIDTH-1], C_MIN})
		                  : ({1'b0, C_MAX} - {s_s1[COORD_WIDTH-1], s_s1});
		neg_s2  <= neg_s1;
		s_s2    <= s_s1;

		if (sh > SW'(room_s2)) begin
			p <= neg_s2 ? C_MIN : C_MAX;
		end else begin
			p <= neg_s2 ? (s_s2 - coord_t'(sh[COORD_WIDTH-1:0]))
			            : (s_s2 + coord_t'(sh[COORD_WIDTH-1:0]));
		end
	end

endmodule
